// ===== design/ljc_pkg.sv =====
// Package for the Lennard-Jones plus Coulomb pair kernel: number format, pipeline
// latencies and the step functions that the arithmetic stages share.
// No dependencies.
`default_nettype none

package ljc_pkg;

  localparam int LJC_NUM_SITE_TYPES = 3;

  localparam int SQ_W        = 32;
  localparam int COEF_W      = 48;
  localparam int RES_W       = 64;
  localparam int MANT_W      = 64;
  localparam int EXP_W       = 12;

  localparam int MUL_LAT     = 2;
  localparam int ADD_LAT     = 5;
  localparam int DIV_STAGES  = 16;
  localparam int DIV_STEPS   = 4;
  localparam int SQRT_STAGES = 8;
  localparam int SQRT_STEPS  = 4;

  typedef logic signed [EXP_W-1:0] exp_t;

  // Sign, normalized mantissa (bit 63 set, or all zero) and binary exponent.
  typedef struct packed {
    logic              neg;
    exp_t              e;
    logic [MANT_W-1:0] m;
  } xnum_t;

  // Control that travels alongside every transaction in the pipeline.
  typedef struct packed {
    logic valid;
    logic kill;
    logic zflag;
  } sband_t;

  typedef struct packed {
    logic [SQ_W:0]     rem;
    logic [MANT_W-1:0] q;
  } div_t;

  typedef struct packed {
    logic [MANT_W-1:0] x;
    logic [MANT_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [RES_W-1:0] val;
    logic             sat;
  } q32_t;

  localparam logic [MANT_W-1:0] TOP_BIT = {1'b1, {(MANT_W-1){1'b0}}};

  // Remainder after the leading quotient bits of 2^94 / d, which are all zero.
  localparam logic [SQ_W:0] DIV_REM_INIT = (SQ_W+1)'(1) << (SQ_W - 2);

  localparam xnum_t XNUM_TWELVE = '{neg: 1'b0, e: exp_t'(-60), m: 64'hC000_0000_0000_0000};
  localparam xnum_t XNUM_SIX    = '{neg: 1'b0, e: exp_t'(-61), m: 64'hC000_0000_0000_0000};

  function automatic xnum_t xneg(input xnum_t x);
    xnum_t r;
    r = x;
    if (x.m != '0) begin
      r.neg = ~x.neg;
    end
    return r;
  endfunction

  // A Q24.24 magnitude placed in the top of the mantissa, not yet normalized.
  function automatic xnum_t mk_coef(input logic [COEF_W-1:0] v, input logic neg);
    xnum_t r;
    r.m   = {v, {(MANT_W-COEF_W){1'b0}}};
    r.e   = exp_t'(-24 - (MANT_W - COEF_W));
    r.neg = neg;
    if (v == '0) begin
      r = '0;
    end
    return r;
  endfunction

  function automatic xnum_t norm_hi(input xnum_t x);
    xnum_t r;
    r = x;
    if (r.m[63:32] == '0) begin
      r.m = r.m << 32;
      r.e = r.e - exp_t'(32);
    end
    if (r.m[63:48] == '0) begin
      r.m = r.m << 16;
      r.e = r.e - exp_t'(16);
    end
    if (r.m[63:56] == '0) begin
      r.m = r.m << 8;
      r.e = r.e - exp_t'(8);
    end
    return r;
  endfunction

  // Finishes normalization and gives zero its canonical form.
  function automatic xnum_t norm_lo(input xnum_t x);
    xnum_t r;
    r = x;
    if (r.m[63:60] == '0) begin
      r.m = r.m << 4;
      r.e = r.e - exp_t'(4);
    end
    if (r.m[63:62] == '0) begin
      r.m = r.m << 2;
      r.e = r.e - exp_t'(2);
    end
    if (r.m[63] == 1'b0) begin
      r.m = r.m << 1;
      r.e = r.e - exp_t'(1);
    end
    if (r.m == '0) begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic [4:0] clz32(input logic [SQ_W-1:0] v);
    logic [4:0]      n;
    logic [SQ_W-1:0] t;
    n = '0;
    t = v;
    if (t[31:16] == '0) begin
      n[4] = 1'b1;
      t    = t << 16;
    end
    if (t[31:24] == '0) begin
      n[3] = 1'b1;
      t    = t << 8;
    end
    if (t[31:28] == '0) begin
      n[2] = 1'b1;
      t    = t << 4;
    end
    if (t[31:30] == '0) begin
      n[1] = 1'b1;
      t    = t << 2;
    end
    if (t[31] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

  // Several restoring division steps; d has bit 31 set.
  function automatic div_t div_steps(input div_t s, input logic [SQ_W-1:0] d);
    div_t          r;
    logic [SQ_W:0] r2;
    r = s;
    for (int j = 0; j < DIV_STEPS; j++) begin
      r2 = {r.rem[SQ_W-1:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        r.rem = r2 - {1'b0, d};
        r.q   = {r.q[MANT_W-2:0], 1'b1};
      end else begin
        r.rem = r2;
        r.q   = {r.q[MANT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Several steps of the digit-by-digit integer square root.
  function automatic sqrt_t sqrt_steps(input sqrt_t s, input int base);
    sqrt_t             r;
    logic [MANT_W-1:0] bitv;
    r = s;
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bitv = 64'd1 << (62 - 2 * (base + j));
      if (r.x >= r.res + bitv) begin
        r.x   = r.x - (r.res + bitv);
        r.res = (r.res >> 1) + bitv;
      end else begin
        r.res = r.res >> 1;
      end
    end
    return r;
  endfunction

  // The quotient lies in [2^62, 2^63], so one shift at most normalizes it.
  function automatic xnum_t recip_out(input logic [MANT_W-1:0] q, input exp_t e0);
    xnum_t r;
    r.neg = 1'b0;
    if (q[MANT_W-1]) begin
      r.m = q;
      r.e = e0;
    end else begin
      r.m = q << 1;
      r.e = e0 - exp_t'(1);
    end
    return r;
  endfunction

  function automatic q32_t to_q32(input xnum_t x);
    q32_t                    r;
    logic signed [EXP_W:0]   k;
    logic signed [EXP_W:0]   nk;
    logic [MANT_W-1:0]       mag;
    r   = '0;
    k   = (EXP_W+1)'(x.e) + (EXP_W+1)'(32);
    nk  = -k;
    mag = '0;
    if (x.m == '0) begin
      r = '0;
    end else if (k >= 0) begin
      if (x.neg && (k == 0) && (x.m == TOP_BIT)) begin
        r.val = TOP_BIT;
      end else begin
        r.sat = 1'b1;
        r.val = x.neg ? TOP_BIT : ~TOP_BIT;
      end
    end else begin
      if (nk >= 64) begin
        mag = '0;
      end else begin
        mag = x.m >> nk[5:0];
      end
      r.val = x.neg ? (~mag + 64'd1) : mag;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/ljc_mul.sv =====
// Two-stage multiplier for the kernel's internal number format.
// Depends on ljc_pkg.
`default_nettype none

module ljc_mul import ljc_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  xnum_t x,
  input  xnum_t y,
  output xnum_t z
);

  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic         neg_r, zero_r;
  exp_t         esum_r;
  logic [127:0] full;
  xnum_t        z_r, z_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r  <= {32'b0, x.m[31:0]} * {32'b0, y.m[31:0]};
      p01_r  <= {32'b0, x.m[31:0]} * {32'b0, y.m[63:32]};
      p10_r  <= {32'b0, x.m[63:32]} * {32'b0, y.m[31:0]};
      p11_r  <= {32'b0, x.m[63:32]} * {32'b0, y.m[63:32]};
      neg_r  <= x.neg ^ y.neg;
      zero_r <= (x.m == '0) || (y.m == '0);
      esum_r <= x.e + y.e;
      z_r    <= z_nxt;
    end
  end

  // The mantissa keeps the top 64 bits of the exact product.
  always_comb begin
    full = {p11_r, 64'b0} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0} + {64'b0, p00_r};
    z_nxt.neg = neg_r;
    if (full[127]) begin
      z_nxt.m = full[127:64];
      z_nxt.e = esum_r + exp_t'(64);
    end else begin
      z_nxt.m = full[126:63];
      z_nxt.e = esum_r + exp_t'(63);
    end
    if (zero_r) begin
      z_nxt = '0;
    end
  end

  assign z = z_r;

endmodule

`default_nettype wire

// ===== design/ljc_add.sv =====
// Five-stage adder for the kernel's internal number format: order, align, add,
// then a two-stage normalizing shift. Depends on ljc_pkg.
`default_nettype none

module ljc_add import ljc_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  xnum_t x,
  input  xnum_t y,
  output xnum_t z
);

  xnum_t               big, lil;
  logic signed [EXP_W:0] d;
  xnum_t               big1_r, big2_r;
  logic [MANT_W-1:0]   sm1_r, sm2_r, sm;
  logic signed [EXP_W:0] d1_r;
  logic                same1_r, same2_r;
  logic [MANT_W:0]     sum;
  xnum_t               s3_nxt, s3_r, s4_r, z_r;

  always_comb begin
    if (x.m == '0) begin
      big = y;
      lil = x;
    end else if (y.m == '0) begin
      big = x;
      lil = y;
    end else if ((x.e > y.e) || ((x.e == y.e) && (x.m >= y.m))) begin
      big = x;
      lil = y;
    end else begin
      big = y;
      lil = x;
    end
    d = (EXP_W+1)'(big.e) - (EXP_W+1)'(lil.e);
  end

  // A zero smaller operand has a zero mantissa, so its shift amount is moot.
  always_comb begin
    if (d1_r >= 64) begin
      sm = '0;
    end else begin
      sm = sm1_r >> d1_r[5:0];
    end
  end

  always_comb begin
    sum        = {1'b0, big2_r.m} + {1'b0, sm2_r};
    s3_nxt.neg = big2_r.neg;
    s3_nxt.e   = big2_r.e;
    if (same2_r) begin
      if (sum[MANT_W]) begin
        s3_nxt.m = {1'b1, sum[MANT_W-1:1]};
        s3_nxt.e = big2_r.e + exp_t'(1);
      end else begin
        s3_nxt.m = sum[MANT_W-1:0];
      end
    end else begin
      s3_nxt.m = big2_r.m - sm2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big1_r  <= big;
      sm1_r   <= lil.m;
      d1_r    <= d;
      same1_r <= (big.neg == lil.neg);
      big2_r  <= big1_r;
      sm2_r   <= sm;
      same2_r <= same1_r;
      s3_r    <= s3_nxt;
      s4_r    <= norm_hi(s3_r);
      z_r     <= norm_lo(s4_r);
    end
  end

  assign z = z_r;

endmodule

`default_nettype wire

// ===== design/lj_coulomb_pair_kernel.sv =====
// Top level of the Lennard-Jones 12-6 plus Coulomb pair kernel.
// Depends on ljc_pkg, ljc_mul and ljc_add.
//
// The kernel takes one transaction per clock: a load writes the repulsion,
// attraction and charge coefficients of one ordered site-type pair, and a
// compute returns a/r^12 - b/r^6 + q/r and the matching force scale for a
// squared distance. Every transaction gives one result, in order. The depth
// comes from the 16-stage reciprocal divider of the squared distance, then
// three multiply levels for r^-6 and the chains of two-stage multipliers and
// five-stage adders behind it; the 8-stage square root and the divider it feeds
// run beside that path. A load is seen by the very next compute. While a valid
// result stalls, the whole pipeline holds and the input channel stalls with it.
`default_nettype none

module lj_coulomb_pair_kernel import ljc_pkg::*; #(
  parameter  int NUM_SITE_TYPES = LJC_NUM_SITE_TYPES,
  localparam int SITE_W         = (NUM_SITE_TYPES > 4) ? 3 : 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic [SITE_W-1:0]        in_site_i,
  input  logic [SITE_W-1:0]        in_site_j,
  input  logic [SQ_W-1:0]          in_sq_dist,
  input  logic [COEF_W-1:0]        in_coef_repulse,
  input  logic [COEF_W-1:0]        in_coef_attract,
  input  logic signed [COEF_W-1:0] in_coef_charge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [RES_W-1:0]  out_force_scale,
  output logic signed [RES_W-1:0]  out_energy_term,
  output logic                     out_saturated
);

  localparam int TAB_DEPTH = NUM_SITE_TYPES * NUM_SITE_TYPES;
  localparam int IDX_W     = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

  // Cycle, counted from the stage-0 registers, at which each value is registered.
  localparam int T_COEF = 2;
  localparam int T_AA   = T_COEF + MUL_LAT;
  localparam int T_IR   = 1 + DIV_STAGES + 1;
  localparam int T_IRR  = 1 + SQRT_STAGES + DIV_STAGES + 1;
  localparam int T_IR2  = T_IR + MUL_LAT;
  localparam int T_IR3  = T_IR2 + MUL_LAT;
  localparam int T_IR6  = T_IR3 + MUL_LAT;
  localparam int T_T1   = T_IR6 + MUL_LAT;
  localparam int T_EC   = T_IRR + MUL_LAT;
  localparam int T_T2   = T_T1 + ADD_LAT;
  localparam int T_T3   = T_T2 + MUL_LAT;
  localparam int T_U4   = T_T3 + MUL_LAT;
  localparam int T_V    = T_EC + MUL_LAT;
  localparam int T_E    = T_T3 + ADD_LAT;
  localparam int T_F    = T_U4 + ADD_LAT;

  localparam int L_A   = T_IR6 - T_COEF;
  localparam int L_B   = T_T1 - T_COEF;
  localparam int L_Q   = T_IRR - T_COEF;
  localparam int L_AA  = T_IR6 - T_AA;
  localparam int L_BB  = T_T1 - T_AA;
  localparam int L_IR  = T_T3 - T_IR;
  localparam int L_IR6 = T_T2 - T_IR6;
  localparam int L_EC  = T_T3 - T_EC;
  localparam int L_V   = T_U4 - T_V;
  localparam int L_E   = T_F - T_E;

  logic             en, acc, site_ok;
  logic [IDX_W-1:0] idx;
  sband_t           sb0_nxt;

  logic [COEF_W-1:0] rep_tab_r [TAB_DEPTH];
  logic [COEF_W-1:0] att_tab_r [TAB_DEPTH];
  logic [COEF_W-1:0] chg_tab_r [TAB_DEPTH];

  sband_t            sb_r [T_F+1];
  logic [SQ_W-1:0]   sq0_r;
  logic [COEF_W-1:0] ca0_r, cb0_r, cq0_r, qmag;
  logic [4:0]        clz0;

  logic [SQ_W-1:0]   da_r, xb_r;
  logic [4:0]        sha_r;
  logic [3:0]        hb_r;

  div_t              diva_r [1:DIV_STAGES];
  logic [SQ_W-1:0]   dda_r  [1:DIV_STAGES];
  logic [4:0]        sha_d_r[1:DIV_STAGES];
  sqrt_t             sqs_r  [1:SQRT_STAGES];
  logic [3:0]        hs_r   [1:SQRT_STAGES];
  div_t              divb_r [1:DIV_STAGES];
  logic [SQ_W-1:0]   ddb_r  [1:DIV_STAGES];
  logic [3:0]        hd_r   [1:DIV_STAGES];

  xnum_t ir_r, irr_r;
  xnum_t an1_r, bn1_r, qn1_r, a2_r, b2_r, q2_r;
  xnum_t aa4, bb4, ir2, ir3, ir6, t1m, u1, ecm, t2s, u2s, t3m, u3m, u4m, vm, en_s, fo_s;

  xnum_t a_d_r   [L_A];
  xnum_t b_d_r   [L_B];
  xnum_t q_d_r   [L_Q];
  xnum_t aa_d_r  [L_AA];
  xnum_t bb_d_r  [L_BB];
  xnum_t ir_d_r  [L_IR];
  xnum_t ir6_d_r [L_IR6];
  xnum_t ec_d_r  [L_EC];
  xnum_t v_d_r   [L_V];
  xnum_t e_d_r   [L_E];

  q32_t                   fq, eq;
  logic                   out_valid_r;
  logic signed [RES_W-1:0] force_r, force_nxt, energy_r, energy_nxt;
  logic                   sat_r, sat_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  assign site_ok = (int'(in_site_i) < NUM_SITE_TYPES) && (int'(in_site_j) < NUM_SITE_TYPES);
  assign idx     = IDX_W'(int'(in_site_i) * NUM_SITE_TYPES + int'(in_site_j));

  always_comb begin
    sb0_nxt.valid = acc;
    sb0_nxt.kill  = in_action || (in_sq_dist == '0);
    sb0_nxt.zflag = !in_action && (in_sq_dist == '0);
  end

  // Coefficient tables: written by a load, read by a compute at acceptance.
  always_ff @(posedge clk) begin
    if (acc && in_action && site_ok) begin
      rep_tab_r[idx] <= in_coef_repulse;
      att_tab_r[idx] <= in_coef_attract;
      chg_tab_r[idx] <= in_coef_charge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= T_F; i++) begin
        sb_r[i] <= '0;
      end
    end else if (en) begin
      sb_r[0] <= sb0_nxt;
      for (int i = 1; i <= T_F; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign clz0 = clz32(sq0_r);
  assign qmag = cq0_r[COEF_W-1] ? (~cq0_r + COEF_W'(1)) : cq0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r <= in_sq_dist;
      ca0_r <= site_ok ? rep_tab_r[idx] : '0;
      cb0_r <= site_ok ? att_tab_r[idx] : '0;
      cq0_r <= site_ok ? chg_tab_r[idx] : '0;
      da_r  <= sq0_r << clz0;
      sha_r <= clz0;
      // The square root wants an even shift that sets bit 30 or bit 31.
      xb_r  <= sq0_r << {clz0[4:1], 1'b0};
      hb_r  <= clz0[4:1];
      an1_r <= norm_hi(mk_coef(ca0_r, 1'b0));
      bn1_r <= norm_hi(mk_coef(cb0_r, 1'b0));
      qn1_r <= norm_hi(mk_coef(qmag, cq0_r[COEF_W-1]));
      a2_r  <= norm_lo(an1_r);
      b2_r  <= norm_lo(bn1_r);
      q2_r  <= norm_lo(qn1_r);
      ir_r  <= recip_out(diva_r[DIV_STAGES].q, exp_t'(sha_d_r[DIV_STAGES]) - exp_t'(70));
      irr_r <= recip_out(divb_r[DIV_STAGES].q, exp_t'(hd_r[DIV_STAGES]) - exp_t'(66));
    end
  end

  // Reciprocal of the squared distance.
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_diva
    div_t            src;
    logic [SQ_W-1:0] dsrc;
    logic [4:0]      ssrc;
    if (k == 1) begin : g_first
      assign src  = '{rem: DIV_REM_INIT, q: '0};
      assign dsrc = da_r;
      assign ssrc = sha_r;
    end else begin : g_next
      assign src  = diva_r[k-1];
      assign dsrc = dda_r[k-1];
      assign ssrc = sha_d_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        diva_r[k]  <= div_steps(src, dsrc);
        dda_r[k]   <= dsrc;
        sha_d_r[k] <= ssrc;
      end
    end
  end

  // Square root of the scaled squared distance.
  for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
    sqrt_t      src;
    logic [3:0] hsrc;
    if (k == 1) begin : g_first
      assign src  = '{x: {xb_r, 32'b0}, res: '0};
      assign hsrc = hb_r;
    end else begin : g_next
      assign src  = sqs_r[k-1];
      assign hsrc = hs_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sqs_r[k] <= sqrt_steps(src, (k - 1) * SQRT_STEPS);
        hs_r[k]  <= hsrc;
      end
    end
  end

  // Reciprocal of the root; the root already has bit 31 set.
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_divb
    div_t            src;
    logic [SQ_W-1:0] dsrc;
    logic [3:0]      hsrc;
    if (k == 1) begin : g_first
      assign src  = '{rem: DIV_REM_INIT, q: '0};
      assign dsrc = sqs_r[SQRT_STAGES].res[SQ_W-1:0];
      assign hsrc = hs_r[SQRT_STAGES];
    end else begin : g_next
      assign src  = divb_r[k-1];
      assign dsrc = ddb_r[k-1];
      assign hsrc = hd_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        divb_r[k] <= div_steps(src, dsrc);
        ddb_r[k]  <= dsrc;
        hd_r[k]   <= hsrc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r[0]   <= a2_r;
      b_d_r[0]   <= b2_r;
      q_d_r[0]   <= q2_r;
      aa_d_r[0]  <= aa4;
      bb_d_r[0]  <= bb4;
      ir_d_r[0]  <= ir_r;
      ir6_d_r[0] <= ir6;
      ec_d_r[0]  <= ecm;
      v_d_r[0]   <= vm;
      e_d_r[0]   <= en_s;
      for (int i = 1; i < L_A; i++)   a_d_r[i]   <= a_d_r[i-1];
      for (int i = 1; i < L_B; i++)   b_d_r[i]   <= b_d_r[i-1];
      for (int i = 1; i < L_Q; i++)   q_d_r[i]   <= q_d_r[i-1];
      for (int i = 1; i < L_AA; i++)  aa_d_r[i]  <= aa_d_r[i-1];
      for (int i = 1; i < L_BB; i++)  bb_d_r[i]  <= bb_d_r[i-1];
      for (int i = 1; i < L_IR; i++)  ir_d_r[i]  <= ir_d_r[i-1];
      for (int i = 1; i < L_IR6; i++) ir6_d_r[i] <= ir6_d_r[i-1];
      for (int i = 1; i < L_EC; i++)  ec_d_r[i]  <= ec_d_r[i-1];
      for (int i = 1; i < L_V; i++)   v_d_r[i]   <= v_d_r[i-1];
      for (int i = 1; i < L_E; i++)   e_d_r[i]   <= e_d_r[i-1];
    end
  end

  ljc_mul u_mul_aa  (.clk(clk), .en(en), .x(a2_r), .y(XNUM_TWELVE), .z(aa4));
  ljc_mul u_mul_bb  (.clk(clk), .en(en), .x(b2_r), .y(XNUM_SIX),    .z(bb4));
  ljc_mul u_mul_ir2 (.clk(clk), .en(en), .x(ir_r), .y(ir_r),        .z(ir2));
  ljc_mul u_mul_ir3 (.clk(clk), .en(en), .x(ir2),  .y(ir_d_r[T_IR2-T_IR-1]), .z(ir3));
  ljc_mul u_mul_ir6 (.clk(clk), .en(en), .x(ir3),  .y(ir3),         .z(ir6));
  ljc_mul u_mul_t1  (.clk(clk), .en(en), .x(a_d_r[L_A-1]),   .y(ir6), .z(t1m));
  ljc_mul u_mul_u1  (.clk(clk), .en(en), .x(aa_d_r[L_AA-1]), .y(ir6), .z(u1));
  ljc_mul u_mul_ec  (.clk(clk), .en(en), .x(q_d_r[L_Q-1]),   .y(irr_r), .z(ecm));

  ljc_add u_add_t2 (.clk(clk), .en(en), .x(t1m), .y(xneg(b_d_r[L_B-1])), .z(t2s));
  ljc_add u_add_u2 (.clk(clk), .en(en), .x(bb_d_r[L_BB-1]), .y(xneg(u1)), .z(u2s));

  ljc_mul u_mul_t3 (.clk(clk), .en(en), .x(t2s), .y(ir6_d_r[L_IR6-1]), .z(t3m));
  ljc_mul u_mul_u3 (.clk(clk), .en(en), .x(u2s), .y(ir6_d_r[L_IR6-1]), .z(u3m));
  ljc_mul u_mul_u4 (.clk(clk), .en(en), .x(u3m), .y(ir_d_r[L_IR-1]),   .z(u4m));
  ljc_mul u_mul_v  (.clk(clk), .en(en), .x(ecm), .y(ir_d_r[T_EC-T_IR-1]), .z(vm));

  ljc_add u_add_e (.clk(clk), .en(en), .x(t3m), .y(ec_d_r[L_EC-1]),     .z(en_s));
  ljc_add u_add_f (.clk(clk), .en(en), .x(u4m), .y(xneg(v_d_r[L_V-1])), .z(fo_s));

  // Loads and zero distances give zero results; of those, only a zero distance flags.
  always_comb begin
    fq = to_q32(fo_s);
    eq = to_q32(e_d_r[L_E-1]);
    if (sb_r[T_F].kill) begin
      force_nxt  = '0;
      energy_nxt = '0;
      sat_nxt    = sb_r[T_F].zflag;
    end else begin
      force_nxt  = fq.val;
      energy_nxt = eq.val;
      sat_nxt    = fq.sat || eq.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sb_r[T_F].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_r  <= force_nxt;
      energy_r <= energy_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_force_scale = force_r;
  assign out_energy_term = energy_r;
  assign out_saturated   = sat_r;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for lj_coulomb_pair_kernel: a directed table, then random load and compute
// transactions; each result is checked against a bit-exact predictor or its typed row.
// Depends on ljc_pkg and the kernel RTL.
`timescale 1ns / 1ps

module testbench;
  import ljc_pkg::*;

  localparam int NSITE       = LJC_NUM_SITE_TYPES;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 80;
  localparam int RANDOM_ITEMS = 400;

  typedef enum logic {ACT_COMPUTE = 1'b0, ACT_LOAD = 1'b1} action_t;

  typedef struct {
    action_t      action;
    logic [1:0]   site_i;
    logic [1:0]   site_j;
    logic [31:0]  sq_dist;
    logic [47:0]  repulse;
    logic [47:0]  attract;
    logic [47:0]  charge;
    bit           typed;
    logic [63:0]  force_typed;
    logic [63:0]  energy_typed;
    logic         sat_typed;
  } pair_item_t;

  typedef struct {
    logic [63:0] force_scale;
    logic [63:0] energy_term;
    logic        saturated;
  } pair_result_t;

  // Extended-range number: sign, normalized 64-bit mantissa, 32-bit integer exponent.
  typedef struct {
    logic [63:0] m;
    int          e;
    bit          neg;
  } fnum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = 1'b0;
  logic [1:0] in_site_i = '0;
  logic [1:0] in_site_j = '0;
  logic [31:0] in_sq_dist = '0;
  logic [47:0] in_coef_repulse = '0;
  logic [47:0] in_coef_attract = '0;
  logic signed [47:0] in_coef_charge = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [63:0] out_force_scale;
  logic signed [63:0] out_energy_term;
  logic out_saturated;

  always #4 clk = ~clk;

  lj_coulomb_pair_kernel i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_site_i, .in_site_j,
    .in_sq_dist, .in_coef_repulse, .in_coef_attract, .in_coef_charge,
    .out_valid, .out_stall, .out_force_scale, .out_energy_term, .out_saturated
  );

  logic [47:0] repulse_coef[NSITE*NSITE];
  logic [47:0] attract_coef[NSITE*NSITE];
  logic [47:0] charge_coef[NSITE*NSITE];
  bit          entry_loaded[NSITE*NSITE];

  pair_item_t   stimulus[$];
  pair_result_t pending_results[$];
  int error_count = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  function automatic fnum_t fmake(logic [63:0] mag, int e, bit neg);
    fnum_t r;
    r.m = mag; r.e = e; r.neg = neg;
    if (mag == 0) begin
      r.e = 0; r.neg = 0;
      return r;
    end
    while (!r.m[63]) begin
      r.m = r.m << 1;
      r.e--;
    end
    return r;
  endfunction

  function automatic fnum_t fneg(fnum_t x);
    if (x.m != 0) x.neg = !x.neg;
    return x;
  endfunction

  function automatic fnum_t fmul(fnum_t x, fnum_t y);
    logic [127:0] p;
    fnum_t r;
    if (x.m == 0 || y.m == 0) return fmake(0, 0, 0);
    p = {64'd0, x.m} * {64'd0, y.m};
    r.neg = x.neg ^ y.neg;
    if (p[127]) begin
      r.m = p[127:64]; r.e = x.e + y.e + 64;
    end else begin
      r.m = p[126:63]; r.e = x.e + y.e + 63;
    end
    return r;
  endfunction

  function automatic fnum_t fadd(fnum_t x, fnum_t y);
    fnum_t big, lil, r;
    logic [64:0] sum;
    logic [63:0] sm;
    int d;
    if (x.m == 0) return y;
    if (y.m == 0) return x;
    if (x.e > y.e || (x.e == y.e && x.m >= y.m)) begin
      big = x; lil = y;
    end else begin
      big = y; lil = x;
    end
    d = big.e - lil.e;
    sm = (d >= 64) ? 64'd0 : (lil.m >> d);
    if (big.neg == lil.neg) begin
      sum = {1'b0, big.m} + {1'b0, sm};
      r.neg = big.neg;
      if (sum[64]) begin
        r.m = sum[64:1]; r.e = big.e + 1;
      end else begin
        r.m = sum[63:0]; r.e = big.e;
      end
      return r;
    end
    return fmake(big.m - sm, big.e, big.neg);
  endfunction

  // 1 / (d * 2^scale) with the quotient floor(2^94 / d) of the normalized d.
  function automatic fnum_t frecip(logic [63:0] d, int scale);
    logic [127:0] q;
    int sh;
    sh = 0;
    while (!d[31]) begin
      d = d << 1;
      sh++;
    end
    q = (128'd1 << 94) / {64'd0, d};
    return fmake(q[63:0], -94 - scale + sh, 0);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] to_fixed(fnum_t x, inout bit sat);
    int k;
    logic [63:0] mag;
    k = x.e + 32;
    if (x.m == 0) return 64'd0;
    if (k >= 0) begin
      if (x.neg && k == 0 && x.m == TOP_BIT) return TOP_BIT;
      sat = 1;
      return x.neg ? TOP_BIT : ~TOP_BIT;
    end
    mag = (-k >= 64) ? 64'd0 : (x.m >> (-k));
    return x.neg ? (~mag + 64'd1) : mag;
  endfunction

  // Updates the coefficient tables and returns the pair interaction.
  function automatic pair_result_t pair_interaction(pair_item_t it);
    pair_result_t res;
    bit in_range, qneg, sat;
    int idx;
    logic [63:0] sq;
    logic [47:0] ca, cb, cq, qmag;
    fnum_t inv_s, inv_r, inv_s3, inv_s6, fa, fb, fq, coul, energy, force_val, fa12, fb6, xs;
    int sh;
    res = '{64'd0, 64'd0, 1'b0};
    in_range = it.site_i < NSITE && it.site_j < NSITE;
    idx = in_range ? it.site_i * NSITE + it.site_j : 0;
    ca = 0; cb = 0; cq = 0; sat = 0;
    if (it.action == ACT_LOAD) begin
      if (in_range) begin
        repulse_coef[idx] = it.repulse;
        attract_coef[idx] = it.attract;
        charge_coef[idx] = it.charge;
        entry_loaded[idx] = 1;
      end
      return res;
    end
    if (it.sq_dist == 0) begin
      res.saturated = 1;
      return res;
    end
    if (in_range) begin
      ca = repulse_coef[idx]; cb = attract_coef[idx]; cq = charge_coef[idx];
    end
    qneg = cq[47];
    qmag = qneg ? (~cq + 48'd1) : cq;
    sq = {32'd0, it.sq_dist};
    inv_s = frecip(sq, -24);
    sh = 0;
    while (sq[31:30] == 2'b00) begin
      sq = sq << 2;
      sh += 2;
    end
    inv_r = frecip(int_sqrt(sq << 32), -28 - sh / 2);
    inv_s3 = fmul(fmul(inv_s, inv_s), inv_s);
    inv_s6 = fmul(inv_s3, inv_s3);
    fa = fmake({16'd0, ca}, -24, 0);
    fb = fmake({16'd0, cb}, -24, 0);
    fq = fmake({16'd0, qmag}, -24, qneg);
    coul = fmul(fq, inv_r);
    energy = fadd(fmul(fadd(fmul(fa, inv_s6), fneg(fb)), inv_s6), coul);
    fa12 = fmul(fa, fmake(64'd12, 0, 0));
    fb6 = fmul(fb, fmake(64'd6, 0, 0));
    xs = fmul(fmul(fadd(fb6, fneg(fmul(fa12, inv_s6))), inv_s6), inv_s);
    force_val = fadd(xs, fneg(fmul(coul, inv_s)));
    res.force_scale = to_fixed(force_val, sat);
    res.energy_term = to_fixed(energy, sat);
    res.saturated = sat;
    return res;
  endfunction

  function automatic pair_item_t make_item(action_t act, logic [1:0] si, logic [1:0] sj,
                                           logic [31:0] sq, logic [47:0] a, logic [47:0] b,
                                           logic [47:0] q);
    pair_item_t it;
    it.action = act; it.site_i = si; it.site_j = sj; it.sq_dist = sq;
    it.repulse = a; it.attract = b; it.charge = q;
    it.typed = 0; it.force_typed = 0; it.energy_typed = 0; it.sat_typed = 0;
    return it;
  endfunction

  task automatic add_row(action_t act, logic [1:0] si, logic [1:0] sj, logic [31:0] sq,
                         logic [47:0] a, logic [47:0] b, logic [47:0] q, bit typed,
                         logic [63:0] fs, logic [63:0] en, logic st);
    pair_item_t it;
    it = make_item(act, si, sj, sq, a, b, q);
    it.typed = typed; it.force_typed = fs; it.energy_typed = en; it.sat_typed = st;
    stimulus.push_back(it);
  endtask

  function automatic logic [47:0] rand_coef();
    case ($urandom_range(3))
      0: return 48'({$urandom, $urandom});
      1: return {16'd0, $urandom};
      2: return {24'd0, 24'($urandom)};
      default: return {28'd0, 20'($urandom)};
    endcase
  endfunction

  function automatic logic [47:0] rand_charge();
    logic [47:0] v;
    v = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) : {24'd0, 24'($urandom)};
    return $urandom_range(1) ? (~v + 48'd1) : v;
  endfunction

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($urandom_range(32'h6400_0000, 32'h0100_0000));
      2: return 32'($urandom_range(32'h00FF_FFFF, 1));
      3: return 32'($urandom_range(255, 1));
      default: return 32'($urandom_range(32'hFFFF_FFFF, 32'hF000_0000));
    endcase
  endfunction

  function automatic pair_item_t random_item();
    int pick, idx;
    logic [1:0] si, sj;
    pick = $urandom_range(99);
    si = 2'($urandom_range(NSITE - 1));
    sj = 2'($urandom_range(NSITE - 1));
    if (pick < 12) begin
      return make_item(ACT_LOAD, si, sj, $urandom, rand_coef(), rand_coef(), rand_charge());
    end else if (pick < 16) begin
      // A site type past the table: the load must change nothing.
      return make_item(ACT_LOAD, $urandom_range(1) ? 2'd3 : si, 2'd3, $urandom,
                       rand_coef(), rand_coef(), rand_charge());
    end else if (pick < 21) begin
      return make_item(ACT_COMPUTE, 2'd3, $urandom_range(1) ? 2'd3 : sj, rand_dist(),
                       rand_coef(), rand_coef(), rand_charge());
    end else if (pick < 25) begin
      return make_item(ACT_COMPUTE, si, sj, 32'd0, rand_coef(), rand_coef(), rand_charge());
    end
    idx = si * NSITE + sj;
    if (!entry_loaded[idx]) begin
      return make_item(ACT_LOAD, si, sj, $urandom, rand_coef(), rand_coef(), rand_charge());
    end
    return make_item(ACT_COMPUTE, si, sj, rand_dist(), rand_coef(), rand_coef(),
                     rand_charge());
  endfunction

  task automatic send_pair(pair_item_t it);
    pair_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= it.action;
    in_site_i <= it.site_i;
    in_site_j <= it.site_j;
    in_sq_dist <= it.sq_dist;
    in_coef_repulse <= it.repulse;
    in_coef_attract <= it.attract;
    in_coef_charge <= it.charge;
    do @(posedge clk); while (in_stall);
    res = pair_interaction(it);
    if (it.typed) begin
      res = '{it.force_typed, it.energy_typed, it.sat_typed};
    end
    pending_results.push_back(res);
  endtask

  // Result side: random stall plus one long hold so the pipeline backs up.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && results_seen == 150) begin
      out_stall <= 1'b1;
      hold_cycles <= 300;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pair_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: force %h energy %h sat %b", $time,
                 out_force_scale, out_energy_term, out_saturated);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_force_scale !== want.force_scale) begin
          $display("%0t: force_scale expected %h actual %h", $time, want.force_scale,
                   out_force_scale);
          error_count++;
        end
        if (out_energy_term !== want.energy_term) begin
          $display("%0t: energy_term expected %h actual %h", $time, want.energy_term,
                   out_energy_term);
          error_count++;
        end
        if (out_saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("testbench: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < NSITE * NSITE; k++) begin
      repulse_coef[k] = 0; attract_coef[k] = 0; charge_coef[k] = 0; entry_loaded[k] = 0;
    end
    add_row(ACT_COMPUTE, 0, 0, 32'd0, 0, 0, 0, 1, 64'd0, 64'd0, 1'b1);
    add_row(ACT_COMPUTE, 3, 1, 32'h0100_0000, 0, 0, 0, 1, 64'd0, 64'd0, 1'b0);
    add_row(ACT_LOAD, 0, 0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
            48'h8000_0000_0000, 1, 64'd0, 64'd0, 1'b0);
    add_row(ACT_LOAD, 3, 3, 32'd0, 48'h1234_5678_9ABC, 48'hFEDC_BA98_7654,
            48'h7FFF_FFFF_FFFF, 1, 64'd0, 64'd0, 1'b0);
    for (int p = 1; p < NSITE * NSITE; p++) begin
      add_row(ACT_LOAD, 2'(p / NSITE), 2'(p % NSITE), 32'd0, 48'h0009_2000_0000 * p,
              48'h0000_5A00_0000 + p, (p % 2) ? 48'hFFFF_FF80_0000 : 48'h0000_0060_0000,
              1, 64'd0, 64'd0, 1'b0);
    end
    add_row(ACT_COMPUTE, 0, 0, 32'd1, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_COMPUTE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_COMPUTE, 0, 1, 32'h0900_0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_COMPUTE, 1, 2, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_COMPUTE, 2, 3, 32'hFFFF_FFFF, 0, 0, 0, 1, 64'd0, 64'd0, 1'b0);
    add_row(ACT_LOAD, 1, 1, 32'd0, 0, 0, 48'h7FFF_FFFF_FFFF, 1, 64'd0, 64'd0, 1'b0);
    add_row(ACT_COMPUTE, 1, 1, 32'h0100_0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 2, 2, 32'd0, 0, 0, 0, 1, 64'd0, 64'd0, 1'b0);
    add_row(ACT_COMPUTE, 2, 2, 32'h0400_0000, 0, 0, 0, 1, 64'd0, 64'd0, 1'b0);
    add_row(ACT_COMPUTE, 2, 0, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 34;
    recv_stall_pct = 69;
    foreach (stimulus[k]) send_pair(stimulus[k]);
    in_valid <= 1'b0;
    // Let the pipeline drain completely before the random traffic starts.
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 69;
        recv_stall_pct = 34;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send_pair(random_item());
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
